// ===== hdl/bdb_pkg.sv =====
// ----------------------------------------------------------------------------
// bdb_pkg
// Shared types and constants for the de Boor path evaluator.
// ----------------------------------------------------------------------------
package bdb_pkg;

    // field widths fixed by the interface
    localparam int COORD_W = 32;
    localparam int DEG_W   = 2;
    localparam int RES_W   = 7;
    localparam int IDX_W   = 6;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 7;

    // point count width, wide enough for the largest store size
    localparam int CNT_W = 6;

    // command queue between front and back
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = 2;

    // blend divider: quotient bits and step counter width
    localparam int BL_QW = 34;
    localparam int BL_CW = 6;

    localparam logic [CFG_IW-1:0] CFG_DEGREE     = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_RESOLUTION = 2'd1;

    localparam logic [DEG_W-1:0] DEGREE_RESET     = 2'd3;
    localparam logic [RES_W-1:0] RESOLUTION_RESET = 7'd20;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      wr;
        logic                      last;
        logic                      dropped;
        logic [CNT_W-1:0]          cnt;
    } t_cmd;

    typedef enum logic [2:0] {
        BL_IDLE,
        BL_MUL,
        BL_PREP,
        BL_DIV,
        BL_DONE
    } t_bl_state;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SPAN,
        BK_FRD,
        BK_FWR,
        BK_RDW,
        BK_BST,
        BK_BWT,
        BK_ERD,
        BK_EMIT
    } t_bk_state;

endpackage

// ===== hdl/bdb_front.sv =====
// ----------------------------------------------------------------------------
// bdb_front
// Input side: counts control points, tags store writes and drops, and
// queues commands for the evaluation engine.
// ----------------------------------------------------------------------------
module bdb_front #(
    parameter int MAX_POINTS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic signed [bdb_pkg::COORD_W-1:0] i_x,
    input  logic signed [bdb_pkg::COORD_W-1:0] i_y,
    input  logic                               i_last,
    output logic                               o_full,
    output bdb_pkg::t_cmd                      o_cmd,
    output logic                               o_cmd_valid,
    input  logic                               i_take
);
    import bdb_pkg::*;

    t_cmd             r_fifo [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wp;
    logic [FQ_AW-1:0] r_rp;
    logic [FQ_AW:0]   r_level;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;

    logic             w_push;
    logic             w_pop;
    logic             w_room;
    t_cmd             w_ent;

    assign o_full      = (r_level == (FQ_AW+1)'(FQ_DEPTH));
    assign o_cmd_valid = (r_level != '0);
    assign o_cmd       = r_fifo[r_rp];
    assign w_push      = i_push & ~o_full;
    assign w_pop       = i_take & o_cmd_valid;
    assign w_room      = (r_cnt < CNT_W'(MAX_POINTS));

    always_comb begin
        w_ent.x       = i_x;
        w_ent.y       = i_y;
        w_ent.wr      = w_room;
        w_ent.last    = i_last;
        w_ent.dropped = r_ovf | ~w_room;
        w_ent.cnt     = w_room ? r_cnt + CNT_W'(1) : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= w_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + FQ_AW'(1);
                if (i_last) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_cnt <= w_ent.cnt;
                    r_ovf <= w_ent.dropped;
                end
            end
            if (w_pop) begin
                r_rp <= r_rp + FQ_AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_level <= r_level + (FQ_AW+1)'(1);
                2'b01:   r_level <= r_level - (FQ_AW+1)'(1);
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

// ===== hdl/bdb_blend.sv =====
// ----------------------------------------------------------------------------
// bdb_blend
// One de Boor blend a + round((b-a)*num/den), ties up, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module bdb_blend #(
    parameter int NUMW = 9
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [bdb_pkg::COORD_W-1:0] i_a,
    input  logic signed [bdb_pkg::COORD_W-1:0] i_b,
    input  logic [NUMW-1:0]                    i_num,
    input  logic [NUMW-1:0]                    i_den,
    output logic                               o_done,
    output logic signed [bdb_pkg::COORD_W-1:0] o_res
);
    import bdb_pkg::*;

    localparam int PRW = NUMW + 34;     // product width
    localparam int NW  = NUMW + 36;     // numerator width
    localparam int RMW = NUMW + 2;      // remainder width

    t_bl_state r_state, n_state;

    logic signed [COORD_W-1:0] r_a;
    logic signed [COORD_W:0]   r_diff;
    logic [NUMW-1:0]           r_num;
    logic [NUMW-1:0]           r_den;
    logic signed [PRW-1:0]     r_prod;
    logic                      r_neg;
    logic [RMW-1:0]            r_rem;
    logic [BL_QW-1:0]          r_q;
    logic [BL_CW-1:0]          r_cnt;

    logic signed [NW-1:0]      w_n;
    logic [NW-1:0]             w_dd;
    logic [NW-1:0]             w_m;
    logic [RMW-1:0]            w_trial;
    logic [RMW-1:0]            w_div;
    logic                      w_ge;
    logic signed [BL_QW:0]     w_qs;
    logic signed [BL_QW:0]     w_sum;

    assign w_dd    = {{(NW-NUMW-1){1'b0}}, r_den, 1'b0};
    assign w_n     = (NW'(r_prod) <<< 1) + $signed({{(NW-NUMW){1'b0}}, r_den});
    // floor of a negative quotient via the magnitude rounded up
    assign w_m     = w_n[NW-1] ? (NW'(-w_n) + w_dd - NW'(1)) : NW'(w_n);
    assign w_trial = {r_rem[RMW-2:0], r_q[BL_QW-1]};
    assign w_div   = {1'b0, r_den, 1'b0};
    assign w_ge    = (w_trial >= w_div);
    assign w_qs    = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign w_sum   = (BL_QW+1)'(r_a) + w_qs;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BL_IDLE: if (i_start) n_state = BL_MUL;
            BL_MUL:  n_state = BL_PREP;
            BL_PREP: n_state = BL_DIV;
            BL_DIV:  if (r_cnt == BL_CW'(BL_QW - 1)) n_state = BL_DONE;
            BL_DONE: n_state = BL_IDLE;
            default: n_state = BL_IDLE;
        endcase
    end

    always_comb begin
        o_done = 1'b0;
        o_res  = r_a;
        unique case (r_state)
            BL_DONE: begin
                o_done = 1'b1;
                o_res  = (r_den == '0) ? r_a : w_sum[COORD_W-1:0];
            end
            default: begin
                o_done = 1'b0;
                o_res  = r_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BL_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BL_IDLE: begin
                if (i_start) begin
                    r_a    <= i_a;
                    r_diff <= (COORD_W+1)'(i_b) - (COORD_W+1)'(i_a);
                    r_num  <= i_num;
                    r_den  <= i_den;
                end
            end
            BL_MUL: begin
                r_prod <= r_diff * $signed({1'b0, r_num});
            end
            BL_PREP: begin
                r_neg <= w_n[NW-1];
                r_rem <= w_m[NW-1:BL_QW];
                r_q   <= w_m[BL_QW-1:0];
                r_cnt <= '0;
            end
            BL_DIV: begin
                r_rem <= w_ge ? (w_trial - w_div) : w_trial;
                r_q   <= {r_q[BL_QW-2:0], w_ge};
                r_cnt <= r_cnt + BL_CW'(1);
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

// ===== hdl/bdb_back.sv =====
// ----------------------------------------------------------------------------
// bdb_back
// Evaluation engine: point store, span tracking, de Boor triangle over a
// small work memory with two blend units, and the result register.
// ----------------------------------------------------------------------------
module bdb_back #(
    parameter int MAX_POINTS     = 8,
    parameter int MAX_DEGREE     = 3,
    parameter int MAX_RESOLUTION = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bdb_pkg::t_cmd                      i_cmd,
    input  logic                               i_cmd_valid,
    output logic                               o_cmd_take,
    input  logic [bdb_pkg::DEG_W-1:0]          i_degree,
    input  logic [bdb_pkg::RES_W-1:0]          i_resolution,
    input  logic                               i_pop,
    output logic                               o_empty,
    output logic signed [bdb_pkg::COORD_W-1:0] o_path_x,
    output logic signed [bdb_pkg::COORD_W-1:0] o_path_y,
    output logic [bdb_pkg::IDX_W-1:0]          o_point_index,
    output logic                               o_last_point,
    output logic                               o_points_dropped
);
    import bdb_pkg::*;

    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int PW   = $clog2(MAX_POINTS);
    localparam int JW   = $clog2(MAX_DEGREE + 1);
    localparam int RW   = $clog2(MAX_RESOLUTION + 1);
    localparam int IW   = $clog2(MAX_RESOLUTION);
    localparam int NUMW = $clog2((MAX_RESOLUTION - 1) * MAX_POINTS + 1);
    localparam int AW   = RW + CW;
    localparam int KW   = CW + 2;

    t_bk_state r_state, n_state;

    logic signed [COORD_W-1:0] r_store_x [MAX_POINTS];
    logic signed [COORD_W-1:0] r_store_y [MAX_POINTS];
    logic signed [COORD_W-1:0] r_work_x [MAX_DEGREE+1];
    logic signed [COORD_W-1:0] r_work_y [MAX_DEGREE+1];
    logic signed [COORD_W-1:0] r_st_x, r_st_y;
    logic signed [COORD_W-1:0] r_wa_x, r_wa_y, r_wb_x, r_wb_y;

    logic [CW-1:0]   r_n, r_d, r_s;
    logic [JW-1:0]   r_p, r_j, r_lev;
    logic [RW-1:0]   r_rm1;
    logic [IW-1:0]   r_i;
    logic [NUMW-1:0] r_id, r_num, r_den;
    logic [AW-1:0]   r_acc;
    logic            r_drop;

    logic                      r_ov;
    logic signed [COORD_W-1:0] r_px, r_py;
    logic [IDX_W-1:0]          r_pi;
    logic                      r_pl, r_pd;

    logic            w_st_we, w_wk_we, w_bl_start, w_out_load, w_run;
    logic [JW-1:0]   w_rd_a, w_rd_b;
    logic [CW-1:0]   w_s_use;
    logic [PW-1:0]   w_st_addr;
    logic            w_span_hit, w_i_last;
    logic signed [KW-1:0] w_ta, w_tb;
    logic [CW-1:0]   w_ka, w_kb;
    logic [NUMW-1:0] w_num, w_den;
    logic [CNT_W-1:0] w_p6;
    logic [RES_W-1:0] w_r;

    logic                      w_bx_done, w_by_done;
    logic signed [COORD_W-1:0] w_bx_res, w_by_res;

    bdb_blend #(.NUMW(NUMW)) u_blend_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bl_start),
        .i_a     (r_wa_x),
        .i_b     (r_wb_x),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_bx_done),
        .o_res   (w_bx_res)
    );

    bdb_blend #(.NUMW(NUMW)) u_blend_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bl_start),
        .i_a     (r_wa_y),
        .i_b     (r_wb_y),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_by_done),
        .o_res   (w_by_res)
    );

    // effective degree and resolution at the start of a run
    always_comb begin
        w_p6 = (i_degree == '0) ? CNT_W'(1) : CNT_W'(i_degree);
        if (w_p6 > CNT_W'(MAX_DEGREE)) w_p6 = CNT_W'(MAX_DEGREE);
        if (w_p6 > i_cmd.cnt - CNT_W'(1)) w_p6 = i_cmd.cnt - CNT_W'(1);
        w_r = i_resolution;
        if (w_r < RES_W'(2)) w_r = RES_W'(2);
        if (w_r > RES_W'(MAX_RESOLUTION)) w_r = RES_W'(MAX_RESOLUTION);
    end

    assign w_s_use    = (r_s > r_d - CW'(1)) ? r_d - CW'(1) : r_s;
    assign w_st_addr  = PW'(CW'(r_j) + w_s_use);
    assign w_span_hit = (r_acc >= AW'(r_rm1));
    assign w_i_last   = (RW'(r_i) == r_rm1);

    // knot numerators of the blend, clamped to [0, n-p]
    assign w_ta = $signed(KW'(w_s_use)) + $signed(KW'(r_j)) - $signed(KW'(r_p));
    assign w_tb = $signed(KW'(w_s_use)) + $signed(KW'(r_j)) + KW'(1)
                  - $signed(KW'(r_lev));
    assign w_ka = (w_ta < 0) ? '0 : (w_ta > $signed(KW'(r_d))) ? r_d : CW'(w_ta);
    assign w_kb = (w_tb < 0) ? '0 : (w_tb > $signed(KW'(r_d))) ? r_d : CW'(w_tb);
    assign w_num = r_id - NUMW'(w_ka) * NUMW'(r_rm1);
    assign w_den = NUMW'(w_kb - w_ka) * NUMW'(r_rm1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_cmd_valid && i_cmd.last) n_state = BK_SPAN;
            BK_SPAN: if (!w_span_hit) n_state = BK_FRD;
            BK_FRD:  n_state = BK_FWR;
            BK_FWR: begin
                if (r_j == r_p) n_state = (r_p == '0) ? BK_ERD : BK_RDW;
                else            n_state = BK_FRD;
            end
            BK_RDW:  n_state = BK_BST;
            BK_BST:  n_state = BK_BWT;
            BK_BWT: begin
                if (w_bx_done) begin
                    if (r_j == r_lev && r_lev == r_p) n_state = BK_ERD;
                    else                              n_state = BK_RDW;
                end
            end
            BK_ERD:  n_state = BK_EMIT;
            BK_EMIT: if (!r_ov) n_state = w_i_last ? BK_IDLE : BK_SPAN;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_take = 1'b0;
        w_st_we    = 1'b0;
        w_run      = 1'b0;
        w_wk_we    = 1'b0;
        w_bl_start = 1'b0;
        w_out_load = 1'b0;
        w_rd_a     = r_j - JW'(1);
        w_rd_b     = r_j;
        unique case (r_state)
            BK_IDLE: begin
                o_cmd_take = i_cmd_valid;
                w_st_we    = i_cmd_valid & i_cmd.wr;
                w_run      = i_cmd_valid & i_cmd.last;
            end
            BK_FWR:  w_wk_we    = 1'b1;
            BK_BST:  w_bl_start = 1'b1;
            BK_BWT:  w_wk_we    = w_bx_done;
            BK_ERD:  w_rd_b     = r_p;
            BK_EMIT: w_out_load = ~r_ov;
            default: w_wk_we    = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) r_ov <= 1'b1;
            else if (i_pop) r_ov <= 1'b0;
        end
    end

    // point store and work memory
    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            r_store_x[PW'(i_cmd.cnt - CNT_W'(1))] <= i_cmd.x;
            r_store_y[PW'(i_cmd.cnt - CNT_W'(1))] <= i_cmd.y;
        end
        r_st_x <= r_store_x[w_st_addr];
        r_st_y <= r_store_y[w_st_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wk_we) begin
            r_work_x[r_j] <= (r_state == BK_FWR) ? r_st_x : w_bx_res;
            r_work_y[r_j] <= (r_state == BK_FWR) ? r_st_y : w_by_res;
        end
        r_wa_x <= r_work_x[w_rd_a];
        r_wa_y <= r_work_y[w_rd_a];
        r_wb_x <= r_work_x[w_rd_b];
        r_wb_y <= r_work_y[w_rd_b];
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (w_run) begin
            r_n    <= CW'(i_cmd.cnt);
            r_p    <= JW'(w_p6);
            r_d    <= CW'(i_cmd.cnt - w_p6);
            r_rm1  <= RW'(w_r - RES_W'(1));
            r_drop <= i_cmd.dropped;
            r_i    <= '0;
            r_id   <= '0;
            r_acc  <= '0;
            r_s    <= '0;
        end
        case (r_state)
            BK_SPAN: begin
                if (w_span_hit) begin
                    r_acc <= r_acc - AW'(r_rm1);
                    r_s   <= r_s + CW'(1);
                end else begin
                    r_j <= '0;
                end
            end
            BK_FWR: begin
                if (r_j == r_p) r_lev <= JW'(1);
                else            r_j   <= r_j + JW'(1);
            end
            BK_RDW: begin
                r_num <= w_num;
                r_den <= w_den;
            end
            BK_BWT: begin
                if (w_bx_done) begin
                    if (r_j == r_lev) begin
                        r_lev <= r_lev + JW'(1);
                        r_j   <= r_p;
                    end else begin
                        r_j <= r_j - JW'(1);
                    end
                end
            end
            BK_EMIT: begin
                if (w_out_load && !w_i_last) begin
                    r_i   <= r_i + IW'(1);
                    r_id  <= r_id + NUMW'(r_d);
                    r_acc <= r_acc + AW'(r_d);
                end
            end
            default: r_lev <= r_lev;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_px <= r_wb_x;
            r_py <= r_wb_y;
            r_pi <= IDX_W'(r_i);
            r_pl <= w_i_last;
            r_pd <= r_drop;
        end
    end

    assign o_empty          = ~r_ov;
    assign o_path_x         = r_px;
    assign o_path_y         = r_py;
    assign o_point_index    = r_pi;
    assign o_last_point     = r_pl;
    assign o_points_dropped = r_pd;

`ifndef SYNTHESIS
    a_blend_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bx_done == w_by_done)
        else $error("blend units out of step");

    a_fetch_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_FRD) |-> ((CW'(r_j) + w_s_use) < r_n))
        else $error("store fetch beyond point count");

    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_EMIT) |-> (RW'(r_i) <= r_rm1))
        else $error("path index beyond resolution");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_ov && (r_pi == IDX_W'($past(r_i)))))
        else $error("result register load lost");
`endif

endmodule

// ===== hdl/bspline_de_boor_path_evaluator.sv =====
// ----------------------------------------------------------------------------
// bspline_de_boor_path_evaluator
// Clamped uniform B-spline path evaluator using de Boor's algorithm.
// ----------------------------------------------------------------------------
// Usage:
//   Control points enter through a queue port (i_push / o_full), one Q15.16
//   x/y pair per beat; i_last_ctrl on the final point starts a run. Points
//   past the store are dropped and flagged on every result of that curve.
//   Results leave through a queue port (o_empty / i_pop): one path point per
//   beat, resolution beats per run, o_last_point on the final one.
//   Configuration (degree, resolution) goes through i_cfg_valid/o_cfg_ready
//   and must only be written while no run is in flight.
// Engine:
//   A point that does not end a curve goes to the store while the engine
//   is idle; a 4-deep command queue absorbs input while a run is busy.
//   Each path point costs p*(p+1)/2 blends (x and y in parallel, one
//   quotient bit per cycle in the blend divider) plus the fetch of p+1
//   points and the span stepping.
// Reset / stall:
//   Reset clears the queue, point count, drop flag and result-valid flag and
//   loads degree 3, resolution 20. A held result stalls the engine; input
//   keeps being queued until the queue is full.
// ----------------------------------------------------------------------------
module bspline_de_boor_path_evaluator #(
    parameter int MAX_POINTS     = 8,
    parameter int MAX_DEGREE     = 3,
    parameter int MAX_RESOLUTION = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic signed [bdb_pkg::COORD_W-1:0] i_ctrl_x,
    input  logic signed [bdb_pkg::COORD_W-1:0] i_ctrl_y,
    input  logic                               i_last_ctrl,
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic signed [bdb_pkg::COORD_W-1:0] o_path_x,
    output logic signed [bdb_pkg::COORD_W-1:0] o_path_y,
    output logic [bdb_pkg::IDX_W-1:0]          o_point_index,
    output logic                               o_last_point,
    output logic                               o_points_dropped,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bdb_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [bdb_pkg::CFG_DW-1:0]         i_cfg_data
);
    import bdb_pkg::*;

    logic [DEG_W-1:0] r_degree;
    logic [RES_W-1:0] r_resolution;

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree     <= DEGREE_RESET;
            r_resolution <= RESOLUTION_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEGREE:     r_degree     <= i_cfg_data[DEG_W-1:0];
                CFG_RESOLUTION: r_resolution <= i_cfg_data[RES_W-1:0];
                default:        r_degree     <= r_degree;
            endcase
        end
    end

    bdb_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_x         (i_ctrl_x),
        .i_y         (i_ctrl_y),
        .i_last      (i_last_ctrl),
        .o_full      (o_full),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_take      (w_cmd_take)
    );

    bdb_back #(
        .MAX_POINTS     (MAX_POINTS),
        .MAX_DEGREE     (MAX_DEGREE),
        .MAX_RESOLUTION (MAX_RESOLUTION)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cmd_valid      (w_cmd_valid),
        .o_cmd_take       (w_cmd_take),
        .i_degree         (r_degree),
        .i_resolution     (r_resolution),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_path_x         (o_path_x),
        .o_path_y         (o_path_y),
        .o_point_index    (o_point_index),
        .o_last_point     (o_last_point),
        .o_points_dropped (o_points_dropped)
    );

endmodule
